@@ rtl/fdm_pkg.sv @@
// Package for the frame difference motion mask.
// Holds pixel widths, gray conversion weights, register indexes and the frame counter codes.
// No dependencies.
package fdm_pkg;

	localparam int PIX_W       = 8;
	localparam int GRAY_SUM_W  = 22;
	localparam int GRAY_SHIFT  = 14;

	localparam logic [GRAY_SUM_W-1:0] GRAY_COEF_B = 22'd1868;
	localparam logic [GRAY_SUM_W-1:0] GRAY_COEF_G = 22'd9617;
	localparam logic [GRAY_SUM_W-1:0] GRAY_COEF_R = 22'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND  = 22'd8192;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THREE_FRAME_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_INPUT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd2;

	localparam logic             RST_THREE_FRAME_MODE = 1'b0;
	localparam logic             RST_COLOR_INPUT      = 1'b1;
	localparam logic [PIX_W-1:0] RST_MOTION_THRESHOLD = 8'd25;

	// completed frames, saturating
	typedef logic [1:0] seen_t;
	localparam seen_t SEEN_NONE = 2'd0;
	localparam seen_t SEEN_ONE  = 2'd1;
	localparam seen_t SEEN_TWO  = 2'd2;

	// forwarding flags for the one-deep read-after-write bypass
	typedef struct packed {
		logic frame;
		logic diff;
	} fwd_t;

endpackage

@@ rtl/frame_difference_motion_mask.sv @@
// Frame difference motion mask: one pixel in, one mask bit out, one pixel per clock sustained
// while the output is not stalled. Each accepted transaction reads the stored previous-frame
// gray value and the stored previous difference at its pixel position. Its pixel is registered
// in stage 1 and its result is then presented by the output register, which holds while the
// output is stalled. The rate is set by the single read and single write port of each frame
// store; a bypass covers back-to-back pixels at the same position. Masks are zero during
// warm-up (first frame, and second frame in three-frame mode). Frame stores are not cleared.
// Depends on fdm_pkg, fdm_gray and fdm_ram.
module frame_difference_motion_mask #(
	parameter int MAX_FRAME_PIXELS = 131072
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fdm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fdm_pkg::PIX_W-1:0]      blue,
	input  logic [fdm_pkg::PIX_W-1:0]      green,
	input  logic [fdm_pkg::PIX_W-1:0]      red,
	input  logic                           last_in_frame,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           motion,
	output logic                           frame_end
);

	localparam int AW = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;

	logic                      three_frame_mode_q;
	logic                      color_input_q;
	logic [fdm_pkg::PIX_W-1:0] motion_threshold_q;

	logic [AW-1:0]     pixel_index_q;
	logic [AW:0]       idx_inc;
	fdm_pkg::seen_t    seen_q;

	logic                      vld_s1;
	logic [fdm_pkg::PIX_W-1:0] blue_s1;
	logic [fdm_pkg::PIX_W-1:0] green_s1;
	logic [fdm_pkg::PIX_W-1:0] red_s1;
	logic                      last_s1;
	logic [AW-1:0]             pos_s1;
	fdm_pkg::seen_t            seen_s1;
	fdm_pkg::fwd_t             fwd_s1;
	logic [fdm_pkg::PIX_W-1:0] fwd_frame_val_s1;
	logic [fdm_pkg::PIX_W-1:0] fwd_diff_val_s1;

	logic vld_s2;
	logic motion_s2;
	logic frame_end_s2;

	logic                      accept;
	logic                      s1_adv;
	logic                      frame_we;
	logic                      diff_we;
	logic                      same_pos;
	logic [fdm_pkg::PIX_W-1:0] gray;
	logic [fdm_pkg::PIX_W-1:0] frame_rd;
	logic [fdm_pkg::PIX_W-1:0] diff_rd;
	logic [fdm_pkg::PIX_W-1:0] prev_frame;
	logic [fdm_pkg::PIX_W-1:0] prev_diff;
	logic [fdm_pkg::PIX_W-1:0] diff;
	logic                      diff_gt;
	logic                      prev_gt;
	logic                      motion_c;

	assign s1_adv   = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign frame_we = vld_s1 && s1_adv;
	assign diff_we  = frame_we && (seen_s1 != fdm_pkg::SEEN_NONE);
	assign same_pos = (pos_s1 == pixel_index_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_frame_mode_q <= fdm_pkg::RST_THREE_FRAME_MODE;
			color_input_q      <= fdm_pkg::RST_COLOR_INPUT;
			motion_threshold_q <= fdm_pkg::RST_MOTION_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdm_pkg::REG_THREE_FRAME_MODE: three_frame_mode_q <= cfg_data[0];
				fdm_pkg::REG_COLOR_INPUT:      color_input_q      <= cfg_data[0];
				fdm_pkg::REG_MOTION_THRESHOLD: motion_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pixel position and frame count
	assign idx_inc = {1'b0, pixel_index_q} + (AW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
			seen_q        <= fdm_pkg::SEEN_NONE;
		end else if (accept) begin
			if (last_in_frame) begin
				pixel_index_q <= '0;
				if (seen_q != fdm_pkg::SEEN_TWO) begin
					seen_q <= seen_q + fdm_pkg::seen_t'(1);
				end
			end else if (idx_inc >= (AW+1)'(MAX_FRAME_PIXELS)) begin
				pixel_index_q <= '0;
			end else begin
				pixel_index_q <= idx_inc[AW-1:0];
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= '0;
		end else if (accept) begin
			vld_s1       <= 1'b1;
			// the store read at this edge misses the write made at the same edge
			fwd_s1.frame <= frame_we && same_pos;
			fwd_s1.diff  <= diff_we && same_pos;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1          <= blue;
			green_s1         <= green;
			red_s1           <= red;
			last_s1          <= last_in_frame;
			pos_s1           <= pixel_index_q;
			seen_s1          <= seen_q;
			fwd_frame_val_s1 <= gray;
			fwd_diff_val_s1  <= diff;
		end
	end

	fdm_ram #(
		.DEPTH (MAX_FRAME_PIXELS),
		.AW    (AW)
	) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (pos_s1),
		.wdata (gray),
		.re    (accept),
		.raddr (pixel_index_q),
		.rdata (frame_rd)
	);

	fdm_ram #(
		.DEPTH (MAX_FRAME_PIXELS),
		.AW    (AW)
	) u_diff_ram (
		.clk   (clk),
		.we    (diff_we),
		.waddr (pos_s1),
		.wdata (diff),
		.re    (accept),
		.raddr (pixel_index_q),
		.rdata (diff_rd)
	);

	fdm_gray u_gray (
		.blue        (blue_s1),
		.green       (green_s1),
		.red         (red_s1),
		.color_input (color_input_q),
		.gray        (gray)
	);

	always_comb begin
		prev_frame = fwd_s1.frame ? fwd_frame_val_s1 : frame_rd;
		prev_diff  = fwd_s1.diff ? fwd_diff_val_s1 : diff_rd;
		diff       = (gray > prev_frame) ? (gray - prev_frame) : (prev_frame - gray);
		diff_gt    = diff > motion_threshold_q;
		prev_gt    = prev_diff > motion_threshold_q;
		motion_c   = 1'b0;
		if (seen_s1 != fdm_pkg::SEEN_NONE) begin
			if (!three_frame_mode_q) begin
				motion_c = diff_gt;
			end else if (seen_s1 == fdm_pkg::SEEN_TWO) begin
				motion_c = diff_gt && prev_gt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			motion_s2    <= motion_c;
			frame_end_s2 <= last_s1;
		end
	end

	assign out_valid = vld_s2;
	assign motion    = motion_s2;
	assign frame_end = frame_end_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2)
		else $error("input stalled with a free pipeline slot");

	a_fwd_diff_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1.diff |-> fwd_s1.frame)
		else $error("difference bypass without frame bypass");

	a_warmup_no_motion: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && seen_s1 == fdm_pkg::SEEN_NONE |-> !motion_c)
		else $error("motion reported during first frame");

	a_index_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_in_frame |=> pixel_index_q == '0)
		else $error("pixel index did not restart after frame end");

	a_seen_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q == fdm_pkg::SEEN_TWO |=> seen_q == fdm_pkg::SEEN_TWO)
		else $error("frame count left saturation");

endmodule

@@ rtl/fdm_gray.sv @@
// BGR to gray conversion with rounding, or blue passed as gray.
// Depends on fdm_pkg.
module fdm_gray (
	input  logic [fdm_pkg::PIX_W-1:0] blue,
	input  logic [fdm_pkg::PIX_W-1:0] green,
	input  logic [fdm_pkg::PIX_W-1:0] red,
	input  logic                      color_input,
	output logic [fdm_pkg::PIX_W-1:0] gray
);

	logic [fdm_pkg::GRAY_SUM_W-1:0] prod_b;
	logic [fdm_pkg::GRAY_SUM_W-1:0] prod_g;
	logic [fdm_pkg::GRAY_SUM_W-1:0] prod_r;
	logic [fdm_pkg::GRAY_SUM_W-1:0] sum;

	always_comb begin
		prod_b = fdm_pkg::GRAY_SUM_W'(blue) * fdm_pkg::GRAY_COEF_B;
		prod_g = fdm_pkg::GRAY_SUM_W'(green) * fdm_pkg::GRAY_COEF_G;
		prod_r = fdm_pkg::GRAY_SUM_W'(red) * fdm_pkg::GRAY_COEF_R;
		sum    = prod_b + prod_g + prod_r + fdm_pkg::GRAY_ROUND;
		if (color_input) begin
			gray = sum[fdm_pkg::GRAY_SHIFT +: fdm_pkg::PIX_W];
		end else begin
			gray = blue;
		end
	end

endmodule

@@ rtl/fdm_ram.sv @@
// Simple dual-port frame store: one write and one registered read per cycle.
// Depends on fdm_pkg for the pixel width.
module fdm_ram #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [fdm_pkg::PIX_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [fdm_pkg::PIX_W-1:0] rdata
);

	logic [fdm_pkg::PIX_W-1:0] mem [DEPTH];
	logic [fdm_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
